FILE: hdl/external_field_force_torque_assert.svh
// assertion macros used by the checker file
`ifndef EXTERNAL_FIELD_FORCE_TORQUE_ASSERT_SVH
`define EXTERNAL_FIELD_FORCE_TORQUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define EFFT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define EFFT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/efft_pkg.sv
package efft_pkg;

  localparam int DW = 32;
  localparam int RW = 48;
  localparam int PW = 48;
  localparam int AW = 52;
  localparam int XW = 53;

  localparam logic signed [DW-1:0] CHG_K = 32'sd1511319;
  localparam logic signed [DW-1:0] DIP_K = 32'sd314697;

  typedef logic [4:0] step_t;

  // multiply schedule
  localparam step_t ST_T0   = 5'd0;
  localparam step_t ST_F0   = 5'd3;
  localparam step_t ST_PC0  = 5'd6;
  localparam step_t ST_D0   = 5'd9;
  localparam step_t ST_PD0  = 5'd12;
  localparam step_t ST_TXA  = 5'd15;
  localparam step_t ST_TXB  = 5'd16;
  localparam step_t ST_TYA  = 5'd17;
  localparam step_t ST_TYB  = 5'd18;
  localparam step_t ST_TZA  = 5'd19;
  localparam step_t ST_TZB  = 5'd20;
  localparam step_t ST_LAST = ST_TZB;

  localparam logic [2:0] REG_FIELD_X   = 3'd0;
  localparam logic [2:0] REG_FIELD_Y   = 3'd1;
  localparam logic [2:0] REG_FIELD_Z   = 3'd2;
  localparam logic [2:0] REG_FIELD_EN  = 3'd3;
  localparam logic [2:0] REG_ATOMP_EN  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_SUM
  } state_t;

  typedef struct packed {
    logic                  vld;
    step_t                 tag;
    logic signed [DW-1:0]  a;
    logic signed [DW-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic                  vld;
    step_t                 tag;
    logic signed [RW-1:0]  rnd;
  } mul_rsp_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [XW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > 53'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -53'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PW-1:0] sat48(input logic signed [XW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > 53'sd140737488355327) begin
      r = 48'sh7fffffffffff;
    end else if (v < -53'sd140737488355328) begin
      r = 48'sh800000000000;
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/efft_mul.sv
module efft_mul import efft_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic signed [63:0] prod_nxt;
  logic signed [63:0] prod_r;
  logic signed [63:0] sum;
  logic               vld_r;
  step_t              tag_r;

  assign prod_nxt = $signed(req.a) * $signed(req.b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req.vld;
    end
    prod_r <= prod_nxt;
    tag_r  <= req.tag;
  end

  // round half up, then floor shift by 16
  assign sum     = prod_r + 64'sd32768;
  assign rsp.vld = vld_r;
  assign rsp.tag = tag_r;
  assign rsp.rnd = sum[63:16];

endmodule

FILE: hdl/external_field_force_torque.sv
// external_field_force_torque: uniform field force, torque and potential per atom
//
// in_*  : one atom per beat; tuser flags the charge and dipole kinds,
//         tlast marks the last atom of a frame
// out_* : one result beat per atom: force, torque, atom and frame potential
// cfg_* : field vector and enables; user must write only while idle, unchecked
//
// every atom runs 21 products through one shared 32x32 multiplier with
// one pipeline register. in_tready is low for the whole computation: a
// new atom is taken only once the prior result is in the output register.
// the result waits in an output register, so the next atom is taken while
// a stalled result is still held; if the receiver is still stalled when
// that atom finishes, the block holds it until the register frees.
// reset clears the configuration, the frame potential and all valid flags.
// frame_pot is cleared after the atom with tlast set.
module external_field_force_torque import efft_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // fixed_charge, fluc_charge, pos_x, pos_y, pos_z, dip_x, dip_y, dip_z
  input  logic [255:0] in_tdata,
  // has_fixed_charge, has_fluc_charge, has_dipole
  input  logic [2:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z, atom_pot, frame_pot
  output logic [271:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  state_t state_r, state_nxt;
  step_t  step_r;

  logic signed [DW-1:0] fld_r [3];
  logic                 fe_r, ape_r;
  logic signed [PW-1:0] pot_r;

  logic signed [DW-1:0] q_r;
  logic                 hq_r, hd_r, last_r;
  logic signed [DW-1:0] pos_r [3];
  logic signed [DW-1:0] dip_r [3];
  logic signed [DW-1:0] t_r   [3];
  logic signed [DW-1:0] f_r   [3];
  logic signed [DW-1:0] d_r   [3];
  logic signed [DW-1:0] tq_r  [3];
  logic signed [AW-1:0] acc_r;
  logic signed [RW-1:0] tmp_r;

  logic signed [DW-1:0] o_f_r  [3];
  logic signed [DW-1:0] o_tq_r [3];
  logic signed [DW-1:0] o_ap_r;
  logic signed [PW-1:0] o_fp_r;
  logic                 out_valid_r;

  logic                 in_acc, load;
  logic signed [XW-1:0] q_sum;
  logic signed [DW-1:0] q_nxt;
  mul_req_t             req;
  mul_rsp_t             rsp;
  logic [1:0]           ridx, widx;
  logic signed [XW-1:0] rnd_x, tmp_x, acc_x, pot_x;
  logic signed [DW-1:0] ap_nxt;
  logic signed [PW-1:0] pot_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load      = (state_r == S_SUM) && (!out_valid_r || out_tready);

  // charge sum
  always_comb begin
    q_sum = '0;
    if (in_tuser[0]) begin
      q_sum = q_sum + {{(XW-DW){in_tdata[31]}}, in_tdata[31:0]};
    end
    if (in_tuser[1]) begin
      q_sum = q_sum + {{(XW-DW){in_tdata[63]}}, in_tdata[63:32]};
    end
    q_nxt = sat32(q_sum);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_RUN;
      S_RUN:   if (step_r == ST_LAST) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_SUM;
      S_SUM:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_r[0] <= '0;
      fld_r[1] <= '0;
      fld_r[2] <= '0;
      fe_r     <= 1'b0;
      ape_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIELD_X:  fld_r[0] <= cfg_data;
        REG_FIELD_Y:  fld_r[1] <= cfg_data;
        REG_FIELD_Z:  fld_r[2] <= cfg_data;
        REG_FIELD_EN: fe_r     <= cfg_data[0];
        REG_ATOMP_EN: ape_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    ridx    = '0;
    req.vld = (state_r == S_RUN);
    req.tag = step_r;
    req.a   = '0;
    req.b   = '0;
    priority if (step_r < ST_F0) begin
      ridx  = 2'(step_r - ST_T0);
      req.a = fld_r[ridx];
      req.b = q_r;
    end else if (step_r < ST_PC0) begin
      ridx  = 2'(step_r - ST_F0);
      req.a = t_r[ridx];
      req.b = CHG_K;
    end else if (step_r < ST_D0) begin
      ridx  = 2'(step_r - ST_PC0);
      req.a = pos_r[ridx];
      req.b = f_r[ridx];
    end else if (step_r < ST_PD0) begin
      ridx  = 2'(step_r - ST_D0);
      req.a = dip_r[ridx];
      req.b = DIP_K;
    end else if (step_r < ST_TXA) begin
      ridx  = 2'(step_r - ST_PD0);
      req.a = d_r[ridx];
      req.b = fld_r[ridx];
    end else begin
      priority case (step_r)
        ST_TXA: begin req.a = d_r[1]; req.b = fld_r[2]; end
        ST_TXB: begin req.a = d_r[2]; req.b = fld_r[1]; end
        ST_TYA: begin req.a = d_r[2]; req.b = fld_r[0]; end
        ST_TYB: begin req.a = d_r[0]; req.b = fld_r[2]; end
        ST_TZA: begin req.a = d_r[0]; req.b = fld_r[1]; end
        default: begin req.a = d_r[1]; req.b = fld_r[0]; end
      endcase
    end
  end

  efft_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign rnd_x = {{(XW-RW){rsp.rnd[RW-1]}}, rsp.rnd};
  assign tmp_x = {{(XW-RW){tmp_r[RW-1]}}, tmp_r};
  assign acc_x = {{(XW-AW){acc_r[AW-1]}}, acc_r};
  assign pot_x = {{(XW-PW){pot_r[PW-1]}}, pot_r};

  always_comb begin
    priority if (rsp.tag < ST_F0)  widx = 2'(rsp.tag - ST_T0);
    else if (rsp.tag < ST_PC0)     widx = 2'(rsp.tag - ST_F0);
    else if (rsp.tag < ST_D0)      widx = 2'(rsp.tag - ST_PC0);
    else if (rsp.tag < ST_PD0)     widx = 2'(rsp.tag - ST_D0);
    else                           widx = 2'(rsp.tag - ST_PD0);
  end

  // capture and write-back
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r      <= q_nxt;
      hq_r     <= in_tuser[0] | in_tuser[1];
      hd_r     <= in_tuser[2];
      last_r   <= in_tlast;
      pos_r[0] <= in_tdata[95:64];
      pos_r[1] <= in_tdata[127:96];
      pos_r[2] <= in_tdata[159:128];
      dip_r[0] <= in_tdata[191:160];
      dip_r[1] <= in_tdata[223:192];
      dip_r[2] <= in_tdata[255:224];
      acc_r    <= '0;
    end else if (rsp.vld) begin
      priority if (rsp.tag < ST_F0) begin
        t_r[widx] <= sat32(rnd_x);
      end else if (rsp.tag < ST_PC0) begin
        f_r[widx] <= hq_r ? sat32(rnd_x) : '0;
      end else if (rsp.tag < ST_D0) begin
        acc_r <= acc_r - rnd_x[AW-1:0];
      end else if (rsp.tag < ST_PD0) begin
        d_r[widx] <= hd_r ? sat32(rnd_x) : '0;
      end else if (rsp.tag < ST_TXA) begin
        acc_r <= acc_r - rnd_x[AW-1:0];
      end else begin
        priority case (rsp.tag)
          ST_TXB: tq_r[0] <= sat32(tmp_x - rnd_x);
          ST_TYB: tq_r[1] <= sat32(tmp_x - rnd_x);
          ST_TZB: tq_r[2] <= sat32(tmp_x - rnd_x);
          default: tmp_r <= rsp.rnd;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (in_acc) begin
      step_r <= '0;
    end else if (state_r == S_RUN) begin
      step_r <= step_r + 5'd1;
    end
  end

  assign ap_nxt  = ape_r ? sat32(acc_x) : '0;
  assign pot_nxt = sat48(pot_x + acc_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      if (last_r) begin
        pot_r <= '0;
      end else if (fe_r) begin
        pot_r <= pot_nxt;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        o_f_r[i]  <= fe_r ? f_r[i]  : '0;
        o_tq_r[i] <= fe_r ? tq_r[i] : '0;
      end
      o_ap_r <= fe_r ? ap_nxt  : '0;
      o_fp_r <= fe_r ? pot_nxt : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_fp_r, o_ap_r, o_tq_r[2], o_tq_r[1], o_tq_r[0],
                       o_f_r[2], o_f_r[1], o_f_r[0]};

endmodule

FILE: hdl/efft_checker.sv
`include "external_field_force_torque_assert.svh"

module efft_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [271:0] out_tdata
);

  // a stalled result beat stays up
  `EFFT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "out beat dropped")

  // a stalled result beat keeps its payload
  `EFFT_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "out payload changed")

  // the shared multiplier keeps the block busy after each input beat
  `EFFT_ASSERT_IMP(a_busy, clk, rst_n, in_tvalid && in_tready, ##20 !in_tready, "input taken too early")

  // a result only appears at the end of a computation
  `EFFT_ASSERT_IMP(a_res_src, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result without work")

endmodule

bind external_field_force_torque efft_checker u_efft_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import efft_pkg::*;

  localparam logic [2:0]  REG_SPARE_LO = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam longint CHARGE_SCALE = 1511319;
  localparam longint DIPOLE_SCALE = 314697;
  localparam int IDLE_CYCLES = 30;

  typedef struct packed {
    logic        last_atom;
    logic        has_dipole;
    logic        has_fluc;
    logic        has_fixed;
    logic [31:0] dip_z;
    logic [31:0] dip_y;
    logic [31:0] dip_x;
    logic [31:0] pos_z;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [31:0] fluc_charge;
    logic [31:0] fixed_charge;
  } atom_t;

  typedef struct packed {
    logic [47:0] frame_pot;
    logic [31:0] atom_pot;
    logic [31:0] torque_z;
    logic [31:0] torque_y;
    logic [31:0] torque_x;
    logic [31:0] force_z;
    logic [31:0] force_y;
    logic [31:0] force_x;
  } result_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [271:0] out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  logic [31:0] field_x_q, field_y_q, field_z_q;
  logic        field_on, atom_pot_on;
  longint      frame_acc;

  result_t field_results_due[$];
  int      mismatches = 0;
  int      gap_max = 12;
  int      stall_max = 12;

  external_field_force_torque uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > 64'sd140737488355327) return 64'sd140737488355327;
    if (v < -64'sd140737488355328) return -64'sd140737488355328;
    return v;
  endfunction

  function automatic result_t field_response(input atom_t a);
    result_t r;
    longint e[3], p[3], d[3], f[3], t[3];
    longint q, pc, pd;
    r = '0;
    pc = 0;
    pd = 0;
    for (int k = 0; k < 3; k++) begin
      f[k] = 0;
      t[k] = 0;
    end
    if (field_on) begin
      e[0] = longint'($signed(field_x_q));
      e[1] = longint'($signed(field_y_q));
      e[2] = longint'($signed(field_z_q));
      if (a.has_fixed || a.has_fluc) begin
        p[0] = longint'($signed(a.pos_x));
        p[1] = longint'($signed(a.pos_y));
        p[2] = longint'($signed(a.pos_z));
        q = 0;
        if (a.has_fixed) q += longint'($signed(a.fixed_charge));
        if (a.has_fluc) q += longint'($signed(a.fluc_charge));
        q = clamp32(q);
        for (int k = 0; k < 3; k++)
          f[k] = clamp32(q_mul(clamp32(q_mul(e[k], q)), CHARGE_SCALE));
        pc = -(q_mul(p[0], f[0]) + q_mul(p[1], f[1]) + q_mul(p[2], f[2]));
      end
      if (a.has_dipole) begin
        d[0] = clamp32(q_mul(longint'($signed(a.dip_x)), DIPOLE_SCALE));
        d[1] = clamp32(q_mul(longint'($signed(a.dip_y)), DIPOLE_SCALE));
        d[2] = clamp32(q_mul(longint'($signed(a.dip_z)), DIPOLE_SCALE));
        t[0] = clamp32(q_mul(d[1], e[2]) - q_mul(d[2], e[1]));
        t[1] = clamp32(q_mul(d[2], e[0]) - q_mul(d[0], e[2]));
        t[2] = clamp32(q_mul(d[0], e[1]) - q_mul(d[1], e[0]));
        pd = -(q_mul(d[0], e[0]) + q_mul(d[1], e[1]) + q_mul(d[2], e[2]));
      end
      if (atom_pot_on) r.atom_pot = 32'(clamp32(pc + pd));
      frame_acc = clamp48(frame_acc + pc + pd);
      r.frame_pot = 48'(frame_acc);
    end
    r.force_x = 32'(f[0]);
    r.force_y = 32'(f[1]);
    r.force_z = 32'(f[2]);
    r.torque_x = 32'(t[0]);
    r.torque_y = 32'(t[1]);
    r.torque_z = 32'(t[2]);
    if (a.last_atom) frame_acc = 0;
    return r;
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'h0;
      3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    endcase
  endfunction

  function automatic atom_t random_atom();
    atom_t a;
    a.has_fixed = 1'($urandom_range(0, 1));
    a.has_fluc = 1'($urandom_range(0, 1));
    a.has_dipole = 1'($urandom_range(0, 1));
    a.fixed_charge = pick_q16();
    a.fluc_charge = pick_q16();
    a.pos_x = pick_q16();
    a.pos_y = pick_q16();
    a.pos_z = pick_q16();
    a.dip_x = pick_q16();
    a.dip_y = pick_q16();
    a.dip_z = pick_q16();
    a.last_atom = ($urandom_range(0, 7) == 0);
    return a;
  endfunction

  function automatic atom_t make_atom(input logic hfix, input logic [31:0] fixq,
                                      input logic hflu, input logic [31:0] fluq,
                                      input logic [31:0] px, input logic [31:0] py,
                                      input logic [31:0] pz, input logic hdip,
                                      input logic [31:0] dx, input logic [31:0] dy,
                                      input logic [31:0] dz, input logic last);
    atom_t a;
    a = '{last, hdip, hflu, hfix, dz, dy, dx, pz, py, px, fluq, fixq};
    return a;
  endfunction

  task automatic send_atom(input atom_t a);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {a.dip_z, a.dip_y, a.dip_x, a.pos_z, a.pos_y, a.pos_x,
                 a.fluc_charge, a.fixed_charge};
    in_tuser <= {a.has_dipole, a.has_fluc, a.has_fixed};
    in_tlast <= a.last_atom;
    do @(posedge clk); while ((in_tvalid && in_tready) !== 1'b1);
    field_results_due.push_back(field_response(a));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (field_results_due.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FIELD_X: field_x_q = value;
      REG_FIELD_Y: field_y_q = value;
      REG_FIELD_Z: field_z_q = value;
      REG_FIELD_EN: field_on = value[0];
      REG_ATOMP_EN: atom_pot_on = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string label, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
    end
  endtask

  // field disabled gives zeros; writes past the register list do nothing
  task automatic test_field_off();
    wait_idle();
    write_reg(REG_FIELD_X, 32'h0002_0000);
    write_reg(REG_FIELD_Y, 32'hffff_0000);
    write_reg(REG_FIELD_Z, 32'h0000_8000);
    write_reg(REG_ATOMP_EN, 32'h1);
    write_reg(REG_SPARE_LO, 32'hffff_ffff);
    write_reg(REG_SPARE_HI, 32'hffff_ffff);
    send_atom(make_atom(1, Q_ONE, 1, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                        1, Q_ONE, Q_MAX, Q_MIN, 0));
    send_atom(make_atom(1, Q_MAX, 0, 0, Q_MIN, Q_MAX, Q_ONE, 1, Q_MIN, 0, Q_ONE, 0));
    send_atom(make_atom(0, 0, 1, Q_MIN, Q_ONE, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 1));
  endtask

  task automatic test_charge_cases();
    wait_idle();
    write_reg(REG_FIELD_X, 32'h0001_8000);
    write_reg(REG_FIELD_Y, 32'hfffd_c000);
    write_reg(REG_FIELD_Z, 32'h0003_0000);
    write_reg(REG_FIELD_EN, 32'h1);
    write_reg(REG_ATOMP_EN, 32'h1);
    send_atom(make_atom(0, Q_ONE, 0, Q_ONE, 32'h0002_0000, 32'hfffc_8000, 32'h000a_0000,
                        0, Q_ONE, Q_ONE, Q_ONE, 0));
    send_atom(make_atom(1, 32'h0000_8000, 0, Q_MAX, 32'h0002_0000, 32'hfffc_8000,
                        32'h000a_0000, 0, 0, 0, 0, 0));
    send_atom(make_atom(0, Q_MAX, 1, 32'hfffe_c000, 32'hfffc_8000, 32'h0002_0000,
                        32'h0000_4000, 0, 0, 0, 0, 0));
    send_atom(make_atom(1, 32'h0000_8000, 1, 32'hfffe_c000, 32'h000a_0000, Q_ONE,
                        32'hfffc_8000, 1, 32'h0001_cccd, 32'hffff_0000, 32'h0000_8000, 0));
    send_atom(make_atom(0, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 1, 32'hfffe_3333,
                        32'h0002_0000, 32'hffff_8000, 1));
  endtask

  task automatic test_extremes();
    wait_idle();
    write_reg(REG_FIELD_X, Q_MAX);
    write_reg(REG_FIELD_Y, Q_MIN);
    write_reg(REG_FIELD_Z, Q_MAX);
    send_atom(make_atom(1, Q_MAX, 1, Q_MAX, Q_MAX, Q_MIN, 0, 1, Q_MAX, Q_MIN, Q_MAX, 0));
    send_atom(make_atom(1, Q_MIN, 1, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 1, Q_MIN, Q_MAX, Q_MIN, 0));
    send_atom(make_atom(1, Q_MAX, 1, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1, 0, 0, 0, 0));
    send_atom(make_atom(0, Q_MAX, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, Q_ONE, Q_MIN, Q_MAX, 0));
    send_atom(make_atom(1, Q_ONE, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, Q_MAX, Q_MAX, Q_MAX, 1));
  endtask

  // frame total saturates high then low, then clears at the end of the frame
  task automatic test_frame_total();
    wait_idle();
    write_reg(REG_FIELD_X, Q_MAX);
    write_reg(REG_FIELD_Y, Q_MAX);
    write_reg(REG_FIELD_Z, Q_MAX);
    send_atom(make_atom(1, Q_MAX, 0, 0, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0));
    send_atom(make_atom(1, Q_MAX, 0, 0, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0));
    repeat (3) send_atom(make_atom(1, Q_MAX, 0, 0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, 0));
    send_atom(make_atom(1, Q_MAX, 0, 0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, 1));
    send_atom(make_atom(1, Q_ONE, 0, 0, Q_ONE, 0, 0, 1, Q_ONE, 0, 0, 1));
  endtask

  task automatic test_potential_off();
    wait_idle();
    write_reg(REG_FIELD_X, 32'h0000_c000);
    write_reg(REG_FIELD_Y, 32'hffff_4000);
    write_reg(REG_FIELD_Z, 32'h0001_0000);
    write_reg(REG_ATOMP_EN, 32'h0);
    send_atom(make_atom(1, Q_ONE, 1, 32'h0000_8000, 32'h0003_0000, 32'hfffe_0000,
                        Q_ONE, 1, Q_ONE, Q_ONE, 32'hffff_0000, 0));
    send_atom(make_atom(0, 0, 1, 32'hffff_0000, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0));
    send_atom(make_atom(0, 0, 0, 0, 0, 0, 0, 1, 32'h0005_0000, 0, Q_ONE, 1));
  endtask

  task automatic test_random_frames();
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(REG_FIELD_X, Q_MAX);
          write_reg(REG_FIELD_Y, Q_MAX);
          write_reg(REG_FIELD_Z, Q_MAX);
        end
        1: begin
          write_reg(REG_FIELD_X, Q_MIN);
          write_reg(REG_FIELD_Y, Q_MIN);
          write_reg(REG_FIELD_Z, Q_MIN);
        end
        default: begin
          write_reg(REG_FIELD_X, pick_q16());
          write_reg(REG_FIELD_Y, pick_q16());
          write_reg(REG_FIELD_Z, pick_q16());
        end
      endcase
      write_reg(REG_FIELD_EN, ($urandom() & ~32'h1) | 32'(phase % 5 != 4));
      write_reg(REG_ATOMP_EN, ($urandom() & ~32'h1) | 32'($urandom_range(0, 3) != 0));
      gap_max = (phase % 3 == 0) ? 0 : 12;
      stall_max = (phase % 4 == 1) ? 0 : 12;
      for (int n = 0; n < 152; n++) send_atom(random_atom());
    end
  endtask

  initial begin
    result_t got, want;
    int w;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      w = $urandom_range(0, stall_max);
      if (w != 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while ((out_tvalid && out_tready) !== 1'b1);
      got = out_tdata;
      if (field_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
      end else begin
        want = field_results_due.pop_front();
        check_field("force_x", want.force_x, got.force_x);
        check_field("force_y", want.force_y, got.force_y);
        check_field("force_z", want.force_z, got.force_z);
        check_field("torque_x", want.torque_x, got.torque_x);
        check_field("torque_y", want.torque_y, got.torque_y);
        check_field("torque_z", want.torque_z, got.torque_z);
        check_field("atom_pot", want.atom_pot, got.atom_pot);
        check_field("frame_pot", want.frame_pot, got.frame_pot);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    field_x_q = '0;
    field_y_q = '0;
    field_z_q = '0;
    field_on = 1'b0;
    atom_pot_on = 1'b0;
    frame_acc = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_off();
    test_charge_cases();
    test_extremes();
    test_frame_total();
    test_potential_off();
    test_random_frames();
    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
